// ===== rtl/ghsbp_pkg.sv =====
// ----------------------------------------------------------------------------
// ghsbp_pkg
// Shared constants, types and index hashing for the geometric history
// branch predictor.
// ----------------------------------------------------------------------------
package ghsbp_pkg;

  localparam int TABLE_COUNT            = 8;
  localparam int INDEX_BITS             = 11;
  localparam int COUNTER_BITS           = 7;
  localparam int HISTORY_BITS           = 128;
  localparam int THRESHOLD_COUNTER_BITS = 7;

  localparam int TABLE_DEPTH  = 1 << INDEX_BITS;
  localparam int BASE_LEN     = 4;
  localparam int SUM_BITS     = 12;
  localparam int THRESH_BITS  = 11;
  localparam int OUT_SUM_BITS = 11;

  typedef logic [INDEX_BITS-1:0]             idx_t;
  typedef logic [COUNTER_BITS-1:0]           ctr_t;
  typedef logic [HISTORY_BITS-1:0]           hist_t;
  typedef logic [THRESH_BITS-1:0]            thresh_t;
  typedef logic [THRESHOLD_COUNTER_BITS-1:0] tctr_t;
  typedef logic signed [SUM_BITS-1:0]        sum_t;

  localparam ctr_t    CTR_MID      = ctr_t'(1 << (COUNTER_BITS - 1));
  localparam ctr_t    CTR_MAX      = ctr_t'((1 << COUNTER_BITS) - 1);
  localparam tctr_t   TC_MID       = tctr_t'(1 << (THRESHOLD_COUNTER_BITS - 1));
  localparam tctr_t   TC_MAX       = tctr_t'((1 << THRESHOLD_COUNTER_BITS) - 1);
  localparam thresh_t THRESH_RESET = thresh_t'(5);
  localparam thresh_t THRESH_MAX   = thresh_t'(2047);

  // XOR the program counter down to one index in chunks of INDEX_BITS.
  function automatic idx_t fold_pc(input logic [31:0] pc);
    idx_t acc;
    acc = '0;
    for (int k = 0; k < 32; k++) begin
      acc[k % INDEX_BITS] = acc[k % INDEX_BITS] ^ pc[k];
    end
    return acc;
  endfunction

  // Index of one table: PC fold, plus for tables above 0 a history fold to INDEX_BITS
  // and one to INDEX_BITS-1 shifted left by one. Bits past the history read as zero.
  function automatic idx_t table_index(input idx_t pcf, input hist_t h, input int t);
    idx_t a;
    idx_t b;
    int   len;
    a   = '0;
    b   = '0;
    len = BASE_LEN << t;
    if (t > 0) begin
      for (int k = 0; k < HISTORY_BITS; k++) begin
        if (k < len) begin
          a[k % INDEX_BITS]       = a[k % INDEX_BITS] ^ h[k];
          b[k % (INDEX_BITS - 1)] = b[k % (INDEX_BITS - 1)] ^ h[k];
        end
      end
    end
    return pcf ^ a ^ idx_t'({b, 1'b0});
  endfunction

  typedef struct packed {
    logic   we;
    idx_t   waddr;
    ctr_t   wdata;
  } ram_wr_t;

endpackage

// ===== rtl/ghsbp_in_if.sv =====
// ----------------------------------------------------------------------------
// ghsbp_in_if
// Resolved branch channel: valid/ready handshake with PC and direction.
// ----------------------------------------------------------------------------
interface ghsbp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] branch_pc;
  logic        actual_taken;

  modport source (output valid, output branch_pc, output actual_taken, input ready);
  modport sink   (input valid, input branch_pc, input actual_taken, output ready);
endinterface

// ===== rtl/ghsbp_out_if.sv =====
// ----------------------------------------------------------------------------
// ghsbp_out_if
// Prediction result channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface ghsbp_out_if;
  logic               valid;
  logic               ready;
  logic               predicted_taken;
  logic signed [10:0] confidence_sum;
  logic               mispredicted;

  modport source (output valid, output predicted_taken, output confidence_sum,
                  output mispredicted, input ready);
  modport sink   (input valid, input predicted_taken, input confidence_sum,
                  input mispredicted, output ready);
endinterface

// ===== rtl/ghsbp_ram.sv =====
// ----------------------------------------------------------------------------
// ghsbp_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module ghsbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/geometric_history_sum_branch_predictor.sv =====
// ----------------------------------------------------------------------------
// geometric_history_sum_branch_predictor
// Summing branch predictor over eight geometric-history counter tables.
// ----------------------------------------------------------------------------
// One resolved branch is accepted every cycle while the result side is not
// stalled. The read stage hashes the indices and reads the eight counter
// RAMs; the stage after it sums the counters, trains them and writes them
// back, with the previous write forwarded to cover the registered read. After
// reset the block runs a clearing pass over all 2048 rows, one row of all eight
// tables per cycle, and accepts no transaction until it is finished.
module geometric_history_sum_branch_predictor (
  input logic        clk,
  input logic        rst_n,
  ghsbp_in_if.sink   in_br,
  ghsbp_out_if.source out_res
);
  import ghsbp_pkg::*;

  // Clearing pass.
  logic clearing_r, clearing_nxt;
  idx_t clr_addr_r, clr_addr_nxt;

  // History and read stage.
  hist_t hist_r, hist_nxt;
  logic  s1_valid_r, s1_valid_nxt;
  logic  s1_taken_r;
  idx_t  s1_idx_r [TABLE_COUNT];
  ctr_t  rd_data  [TABLE_COUNT];

  // Forwarding of the most recent training write.
  logic  fwd_valid_r, fwd_valid_nxt;
  idx_t  fwd_idx_r  [TABLE_COUNT];
  ctr_t  fwd_data_r [TABLE_COUNT];

  thresh_t thresh_r, thresh_nxt;
  tctr_t   tctr_r, tctr_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_pred_r;
  logic signed [10:0] out_sum_r;
  logic               out_miss_r;

  logic    accept, s1_adv, train, pred, miss;
  idx_t    pcf;
  idx_t    rd_idx [TABLE_COUNT];
  ctr_t    cur    [TABLE_COUNT];
  ctr_t    upd    [TABLE_COUNT];
  ram_wr_t wr     [TABLE_COUNT];
  sum_t    sum;
  sum_t    mag;

  assign s1_adv      = s1_valid_r && (!out_valid_r || out_res.ready);
  assign in_br.ready = !clearing_r && (!s1_valid_r || s1_adv);
  assign accept      = in_br.valid && in_br.ready;
  assign pcf         = fold_pc(in_br.branch_pc);

  for (genvar t = 0; t < TABLE_COUNT; t++) begin : g_tbl
    assign rd_idx[t] = table_index(pcf, hist_r, t);

    ghsbp_ram #(.WIDTH(COUNTER_BITS), .DEPTH(TABLE_DEPTH)) u_ram (
      .clk   (clk),
      .we    (wr[t].we),
      .waddr (wr[t].waddr),
      .wdata (wr[t].wdata),
      .re    (accept),
      .raddr (rd_idx[t]),
      .rdata (rd_data[t])
    );

    always_comb begin
      cur[t] = (fwd_valid_r && fwd_idx_r[t] == s1_idx_r[t]) ? fwd_data_r[t] : rd_data[t];
      if (s1_taken_r) begin
        upd[t] = (cur[t] < CTR_MAX) ? cur[t] + ctr_t'(1) : cur[t];
      end else begin
        upd[t] = (cur[t] > '0) ? cur[t] - ctr_t'(1) : cur[t];
      end
      if (clearing_r) begin
        wr[t] = '{we: 1'b1, waddr: clr_addr_r, wdata: CTR_MID};
      end else begin
        wr[t] = '{we: s1_adv && train, waddr: s1_idx_r[t], wdata: upd[t]};
      end
    end

    always_ff @(posedge clk) begin
      if (accept) begin
        s1_idx_r[t] <= rd_idx[t];
      end
      if (!clearing_r && s1_adv && train) begin
        fwd_idx_r[t]  <= s1_idx_r[t];
        fwd_data_r[t] <= upd[t];
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int t = 0; t < TABLE_COUNT; t++) begin
      sum = sum + sum_t'({1'b0, cur[t], 1'b1}) - sum_t'({1'b0, CTR_MID, 1'b0});
    end
    mag   = sum[SUM_BITS-1] ? -sum : sum;
    pred  = !sum[SUM_BITS-1];
    miss  = pred != s1_taken_r;
    train = miss || (mag < sum_t'({1'b0, thresh_r}));
  end

  always_comb begin
    thresh_nxt = thresh_r;
    tctr_nxt   = tctr_r;
    if (s1_adv) begin
      if (miss) begin
        if (tctr_r < TC_MAX) begin
          tctr_nxt = tctr_r + tctr_t'(1);
        end
        if (tctr_nxt == TC_MAX) begin
          if (thresh_r < THRESH_MAX) begin
            thresh_nxt = thresh_r + thresh_t'(1);
          end
          tctr_nxt = TC_MID;
        end
      end else if (train) begin
        if (tctr_r > '0) begin
          tctr_nxt = tctr_r - tctr_t'(1);
        end
        if (tctr_nxt == '0) begin
          if (thresh_r > '0) begin
            thresh_nxt = thresh_r - thresh_t'(1);
          end
          tctr_nxt = TC_MID;
        end
      end
    end
  end

  always_comb begin
    clearing_nxt  = clearing_r;
    clr_addr_nxt  = clr_addr_r;
    if (clearing_r) begin
      clr_addr_nxt = clr_addr_r + idx_t'(1);
      if (clr_addr_r == idx_t'(TABLE_DEPTH - 1)) begin
        clearing_nxt = 1'b0;
      end
    end
    hist_nxt      = accept ? {hist_r[HISTORY_BITS-2:0], in_br.actual_taken} : hist_r;
    s1_valid_nxt  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    fwd_valid_nxt = fwd_valid_r || (!clearing_r && s1_adv && train);
    out_valid_nxt = s1_adv ? 1'b1 : (out_res.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_addr_r  <= '0;
      hist_r      <= '0;
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      thresh_r    <= THRESH_RESET;
      tctr_r      <= TC_MID;
      out_valid_r <= 1'b0;
    end else begin
      clearing_r  <= clearing_nxt;
      clr_addr_r  <= clr_addr_nxt;
      hist_r      <= hist_nxt;
      s1_valid_r  <= s1_valid_nxt;
      fwd_valid_r <= fwd_valid_nxt;
      thresh_r    <= thresh_nxt;
      tctr_r      <= tctr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_taken_r <= in_br.actual_taken;
    end
    if (s1_adv) begin
      out_pred_r <= pred;
      out_sum_r  <= sum[OUT_SUM_BITS-1:0];
      out_miss_r <= miss;
    end
  end

  assign out_res.valid           = out_valid_r;
  assign out_res.predicted_taken = out_pred_r;
  assign out_res.confidence_sum  = out_sum_r;
  assign out_res.mispredicted    = out_miss_r;

  // An accepted branch is always present in the read stage in the cycle after acceptance.
  a_accept_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid_r) else $error("accepted branch missing from read stage");

  // No branch is taken in while the tables are being cleared.
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !in_br.ready) else $error("ready raised during clearing pass");

  // A result left untaken is not overwritten by the next branch.
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res.ready) |-> !s1_adv) else $error("pending result overwritten");

  // The threshold changes only when a result is produced, by at most one.
  a_thresh_step: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> $stable(thresh_r)) else $error("threshold changed without a result");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the geometric history branch predictor. Random and
// directed resolved branches go in under bursty valid; each result is checked
// field by field against a predictor model kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import ghsbp_pkg::*;

  typedef struct packed {
    logic [31:0] pc;
    logic        taken;
  } branch_t;

  typedef struct packed {
    logic               pred;
    logic signed [10:0] sum;
    logic               miss;
  } outcome_t;

  localparam int N_RANDOM    = 1576;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ghsbp_in_if  br_if ();
  ghsbp_out_if res_if ();

  geometric_history_sum_branch_predictor u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_br   (br_if.sink),
    .out_res (res_if.source)
  );

  always #1 clk = ~clk;

  // Predictor state kept by the bench.
  logic [COUNTER_BITS-1:0] shadow_ctr [TABLE_COUNT][TABLE_DEPTH];
  logic [HISTORY_BITS-1:0] shadow_hist;
  int unsigned             shadow_thresh;
  int unsigned             shadow_tctr;

  branch_t  pending_branches[$];
  outcome_t expected_outcomes[$];
  int       n_errors = 0;
  int       n_checked = 0;
  int       n_miss = 0;
  bit       stimulus_done = 1'b0;
  bit       hold_sender = 1'b0;
  longint   cycle_count = 0;

  function automatic logic [INDEX_BITS-1:0] hash_pc(logic [31:0] pc);
    logic [INDEX_BITS-1:0] acc;
    acc = '0;
    for (int k = 0; k < 32; k++) acc[k % INDEX_BITS] ^= pc[k];
    return acc;
  endfunction

  function automatic logic [INDEX_BITS-1:0] hash_history(int len, int w);
    logic [INDEX_BITS-1:0] acc;
    acc = '0;
    for (int k = 0; k < len && k < HISTORY_BITS; k++) acc[k % w] ^= shadow_hist[k];
    return acc;
  endfunction

  function automatic outcome_t predict_and_train(branch_t b);
    logic [INDEX_BITS-1:0] row [TABLE_COUNT];
    logic [INDEX_BITS-1:0] pcf, hb;
    int                    total, mag, c;
    outcome_t              o;
    pcf   = hash_pc(b.pc);
    total = 0;
    for (int t = 0; t < TABLE_COUNT; t++) begin
      row[t] = pcf;
      if (t > 0) begin
        hb = hash_history(BASE_LEN << t, INDEX_BITS - 1);
        row[t] = row[t] ^ hash_history(BASE_LEN << t, INDEX_BITS) ^ {hb[INDEX_BITS-2:0], 1'b0};
      end
      total += 2 * (int'(shadow_ctr[t][row[t]]) - int'(CTR_MID)) + 1;
    end
    o.pred = (total >= 0);
    o.miss = (o.pred != b.taken);
    o.sum  = total[10:0];
    mag    = (total < 0) ? -total : total;
    if (o.miss || mag < shadow_thresh) begin
      for (int t = 0; t < TABLE_COUNT; t++) begin
        c = int'(shadow_ctr[t][row[t]]);
        if (b.taken && c < int'(CTR_MAX)) c++;
        else if (!b.taken && c > 0) c--;
        shadow_ctr[t][row[t]] = c[COUNTER_BITS-1:0];
      end
    end
    if (o.miss) begin
      if (shadow_tctr < 32'(TC_MAX)) shadow_tctr++;
      if (shadow_tctr == 32'(TC_MAX)) begin
        if (shadow_thresh < 32'(THRESH_MAX)) shadow_thresh++;
        shadow_tctr = 32'(TC_MID);
      end
    end else if (mag < shadow_thresh) begin
      if (shadow_tctr > 0) shadow_tctr--;
      if (shadow_tctr == 0) begin
        if (shadow_thresh > 0) shadow_thresh--;
        shadow_tctr = 32'(TC_MID);
      end
    end
    shadow_hist = {shadow_hist[HISTORY_BITS-2:0], b.taken};
    return o;
  endfunction

  // A loop of a few branch sites with patterned directions trains deeply;
  // the rest is scattered noise.
  task automatic queue_random_branches(int n);
    logic [31:0] sites [8];
    int          pat;
    for (int s = 0; s < 8; s++) sites[s] = $urandom;
    pat = 0;
    for (int i = 0; i < n; i++) begin
      branch_t b;
      if ($urandom_range(9) < 7) begin
        b.pc    = sites[i % 8];
        b.taken = 1'(((pat >> (i % 8)) & 1) ^ int'($urandom_range(19) == 0));
        if (i % 64 == 0) pat = $urandom;
      end else begin
        b.pc    = $urandom;
        b.taken = 1'($urandom_range(1));
      end
      pending_branches.push_back(b);
    end
  endtask

  initial begin
    branch_t b;
    for (int t = 0; t < TABLE_COUNT; t++)
      for (int r = 0; r < TABLE_DEPTH; r++) shadow_ctr[t][r] = CTR_MID;
    shadow_hist   = '0;
    shadow_thresh = 32'(THRESH_RESET);
    shadow_tctr   = 32'(TC_MID);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: PC extremes, both directions, and a repeated site whose
    // direction alternates.
    b = '{32'h0000_0000, 1'b0}; pending_branches.push_back(b);
    b = '{32'hFFFF_FFFF, 1'b1}; pending_branches.push_back(b);
    b = '{32'hAAAA_AAAA, 1'b0}; pending_branches.push_back(b);
    b = '{32'h5555_5555, 1'b1}; pending_branches.push_back(b);
    for (int i = 0; i < 20; i++) begin
      b = '{32'h0000_1234, i[0]};
      pending_branches.push_back(b);
    end
    wait (pending_branches.size() == 0 && expected_outcomes.size() == 0);

    // Long taken run, which fills the history, then a long not-taken run at the same site.
    for (int i = 0; i < 200; i++) begin
      b = '{32'hFFFF_0000, 1'b1};
      pending_branches.push_back(b);
    end
    for (int i = 0; i < 150; i++) begin
      b = '{32'hFFFF_0000, 1'b0};
      pending_branches.push_back(b);
    end
    // Wait for the pipeline to drain before carrying on.
    wait (pending_branches.size() == 0);
    hold_sender = 1'b1;
    wait (expected_outcomes.size() == 0);
    hold_sender = 1'b0;
    queue_random_branches(N_RANDOM);
    wait (pending_branches.size() == 0);
    stimulus_done = 1'b1;
  end

  // Driver: bursts of valid separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  initial begin
    br_if.valid        = 1'b0;
    br_if.branch_pc    = '0;
    br_if.actual_taken = 1'b0;
    res_if.ready       = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (br_if.valid && br_if.ready) begin
        expected_outcomes.push_back(predict_and_train(pending_branches.pop_front()));
      end
      // A gap only starts once the offered transaction has been taken.
      if (gap_left > 0 && (!br_if.valid || br_if.ready)) begin
        gap_left <= gap_left - 1;
        br_if.valid <= 1'b0;
      end else if (!br_if.valid || br_if.ready) begin
        if (pending_branches.size() > 0 && !hold_sender) begin
          br_if.valid        <= 1'b1;
          br_if.branch_pc    <= pending_branches[0].pc;
          br_if.actual_taken <= pending_branches[0].taken;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(40, 1);
            if ($urandom_range(3) == 0) gap_left <= $urandom_range(6, 1);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          br_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall-free stretches alternate with stretches of random receiver stalls.
  always @(posedge clk) begin
    if (rst_n) begin
      if (res_if.valid && res_if.ready) begin
        if (expected_outcomes.size() == 0) begin
          $error("result with no expectation waiting");
          n_errors++;
        end else begin
          outcome_t e;
          e = expected_outcomes.pop_front();
          n_checked++;
          if (e.miss) n_miss++;
          if (res_if.predicted_taken !== e.pred) begin
            $error("predicted_taken: expected %0d actual %0d", e.pred,
                   res_if.predicted_taken);
            n_errors++;
          end
          if (res_if.confidence_sum !== e.sum) begin
            $error("confidence_sum: expected %0d actual %0d", e.sum,
                   res_if.confidence_sum);
            n_errors++;
          end
          if (res_if.mispredicted !== e.miss) begin
            $error("mispredicted: expected %0d actual %0d", e.miss,
                   res_if.mispredicted);
            n_errors++;
          end
        end
      end
      res_if.ready <= ((cycle_count / 300) % 2 == 0) ? 1'b1 : ($urandom_range(2) != 0);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    wait (stimulus_done && expected_outcomes.size() == 0);
    repeat (20) @(posedge clk);
    $display("Checked %0d predictions, %0d of them mispredicted; final threshold %0d.",
             n_checked, n_miss, shadow_thresh);
    if (n_errors == 0 && expected_outcomes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== geometric_history_sum_branch_predictor.f =====
rtl/ghsbp_pkg.sv
rtl/ghsbp_in_if.sv
rtl/ghsbp_out_if.sv
rtl/ghsbp_ram.sv
rtl/geometric_history_sum_branch_predictor.sv
tb/tb.sv
